// ===== sv/wptd_pkg.sv =====
// ----------------------------------------------------------------------------
// wptd_pkg
// Shared types, codes and translation tables for the text stream decoder.
// ----------------------------------------------------------------------------
package wptd_pkg;

  localparam logic [1:0] PHASE_HEADER = 2'd0;
  localparam logic [1:0] PHASE_FOOTER = 2'd1;
  localparam logic [1:0] PHASE_BODY   = 2'd2;

  localparam logic [1:0] ALIGN_NORMAL = 2'd0;
  localparam logic [1:0] ALIGN_SUB    = 2'd1;
  localparam logic [1:0] ALIGN_SUPER  = 2'd2;

  localparam logic [0:0] KIND_CHAR = 1'b0;
  localparam logic [0:0] KIND_END  = 1'b1;

  localparam logic [0:0] CFG_PC_FORMAT = 1'b0;
  localparam logic [0:0] CFG_TEXT_END  = 1'b1;

  localparam logic [7:0] CODE_END       = 8'd0;
  localparam logic [7:0] CODE_FORMFEED  = 8'd12;
  localparam logic [7:0] CODE_BOLD      = 8'd15;
  localparam logic [7:0] CODE_UNDERLINE = 8'd16;
  localparam logic [7:0] CODE_SUB       = 8'd17;
  localparam logic [7:0] CODE_SUPER     = 8'd18;
  localparam logic [7:0] CODE_ITALIC    = 8'd19;
  localparam logic [7:0] CODE_DROP      = 8'd30;
  localparam logic [7:0] NATIVE_POUND   = 8'd96;
  localparam logic [7:0] NATIVE_LO      = 8'd127;
  localparam logic [7:0] NATIVE_HI      = 8'd187;

  localparam logic [31:0] START_OFFSET = 32'd20;

  typedef struct packed {
    logic        item_kind;
    logic [1:0]  section;
    logic [15:0] code_point;
    logic        bold;
    logic        underline;
    logic        italic;
    logic [1:0]  vertical_align;
  } result_t;

  function automatic logic [15:0] cp437_high(input logic [6:0] i);
    logic [15:0] t [128];
    t = '{
      16'h00c7, 16'h00fc, 16'h00e9, 16'h00e2, 16'h00e4, 16'h00e0, 16'h00e5, 16'h00e7,
      16'h00ea, 16'h00eb, 16'h00e8, 16'h00ef, 16'h00ee, 16'h00ec, 16'h00c4, 16'h00c5,
      16'h00c9, 16'h00e6, 16'h00c6, 16'h00f4, 16'h00f6, 16'h00f2, 16'h00fb, 16'h00f9,
      16'h00ff, 16'h00d6, 16'h00dc, 16'h00a2, 16'h00a3, 16'h00a5, 16'h20a7, 16'h0192,
      16'h00e1, 16'h00ed, 16'h00f3, 16'h00fa, 16'h00f1, 16'h00d1, 16'h00aa, 16'h00ba,
      16'h00bf, 16'h2310, 16'h00ac, 16'h00bd, 16'h00bc, 16'h00a1, 16'h00ab, 16'h00bb,
      16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
      16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255d, 16'h255c, 16'h255b, 16'h2510,
      16'h2514, 16'h2534, 16'h252c, 16'h251c, 16'h2500, 16'h253c, 16'h255e, 16'h255f,
      16'h255a, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256c, 16'h2567,
      16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256b,
      16'h256a, 16'h2518, 16'h250c, 16'h2588, 16'h2584, 16'h258c, 16'h2590, 16'h2580,
      16'h03b1, 16'h00df, 16'h0393, 16'h03c0, 16'h03a3, 16'h03c3, 16'h03bc, 16'h03c4,
      16'h03a6, 16'h0398, 16'h03a9, 16'h03b4, 16'h221e, 16'h03c6, 16'h03b5, 16'h2229,
      16'h2261, 16'h00b1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00f7, 16'h2248,
      16'h00b0, 16'h2219, 16'h00b7, 16'h221a, 16'h207f, 16'h00b2, 16'h25a0, 16'h00a0
    };
    return t[i];
  endfunction

  function automatic logic [15:0] native_mid(input logic [5:0] i);
    logic [15:0] t [64];
    t = '{
      16'd169, 16'd228, 16'd227, 16'd229, 16'd233, 16'd246, 16'd245, 16'd248,
      16'd252, 16'd231, 16'd241, 16'd230, 16'd339, 16'd225, 16'd224, 16'd226,
      16'd235, 16'd232, 16'd234, 16'd239, 16'd237, 16'd236, 16'd238, 16'd243,
      16'd242, 16'd244, 16'd250, 16'd249, 16'd251, 16'd223, 16'd162, 16'd165,
      16'd180, 16'd196, 16'd195, 16'd194, 16'd201, 16'd214, 16'd213, 16'd216,
      16'd220, 16'd199, 16'd209, 16'd198, 16'd338, 16'h03B1, 16'h03B4, 16'h0398,
      16'h03BB, 16'h03BC, 16'h03C6, 16'h03A6, 16'd161, 16'd191, 16'h20AC, 16'd167,
      16'h2295, 16'd171, 16'd187, 16'd176, 16'd247, 16'd0, 16'd0, 16'd0
    };
    return t[i];
  endfunction

endpackage

// ===== sv/wptd_xlate.sv =====
// ----------------------------------------------------------------------------
// wptd_xlate
// Byte to Unicode translation, CP437 or native character set.
// ----------------------------------------------------------------------------
module wptd_xlate (
  input  logic        pc_format,
  input  logic [7:0]  raw,
  output logic [15:0] code_point
);

  logic [7:0] nat_idx;

  assign nat_idx = raw - wptd_pkg::NATIVE_LO;

  always_comb begin
    if (pc_format) begin
      if (raw[7])             code_point = wptd_pkg::cp437_high(raw[6:0]);
      else if (raw == 8'd26)  code_point = 16'h001c;
      else if (raw == 8'd28)  code_point = 16'h007f;
      else if (raw == 8'd127) code_point = 16'h001a;
      else                    code_point = {8'd0, raw};
    end else begin
      if (raw == wptd_pkg::NATIVE_POUND) code_point = 16'd163;
      else if (raw < wptd_pkg::NATIVE_LO || raw > wptd_pkg::NATIVE_HI)
        code_point = {8'd0, raw};
      else code_point = wptd_pkg::native_mid(nat_idx[5:0]);
    end
  end

endmodule

// ===== sv/word_processor_text_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// word_processor_text_stream_decoder
// Decodes text-area bytes into characters, section ends and attributes.
// ----------------------------------------------------------------------------
// One word is taken per cycle while in_stall is low. Its result, if any,
// goes to the output register, or to the one skid entry if the output is
// stalled. While the output is stalled one more word is taken into the skid
// entry and the input then stalls until the output word leaves. Decode state
// (phase, offset, attributes) is updated in the cycle a word is accepted.
module word_processor_text_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_raw_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_item_kind,
  output logic [1:0]  out_section,
  output logic [15:0] out_code_point,
  output logic        out_bold,
  output logic        out_underline,
  output logic        out_italic,
  output logic [1:0]  out_vertical_align
);

  logic        pc_format_r;
  logic [31:0] text_end_r;
  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] offset_r;
  logic        bold_r, bold_nxt, ul_r, ul_nxt, it_r, it_nxt;
  logic        sub_r, sub_nxt, sup_r, sup_nxt;
  logic [1:0]  align_r, align_nxt;
  logic [15:0] xcode;
  logic        emit;
  wptd_pkg::result_t res;
  wptd_pkg::result_t out_r, skid_r;
  logic        out_v_r, skid_v_r;
  logic        accept, out_take;

  assign in_stall = skid_v_r;
  assign accept   = in_valid && !in_stall;
  assign out_take = out_v_r && !out_stall;

  wptd_xlate u_xlate (
    .pc_format  (pc_format_r),
    .raw        (in_raw_byte),
    .code_point (xcode)
  );

  always_comb begin
    phase_nxt = phase_r;
    bold_nxt = bold_r; ul_nxt = ul_r; it_nxt = it_r;
    sub_nxt = sub_r; sup_nxt = sup_r; align_nxt = align_r;
    emit = 1'b0;
    res = '0;
    if (phase_r != wptd_pkg::PHASE_BODY) begin
      emit = 1'b1;
      res.section = phase_r;
      if (in_raw_byte == wptd_pkg::CODE_END) begin
        res.item_kind = wptd_pkg::KIND_END;
        phase_nxt = (phase_r == wptd_pkg::PHASE_HEADER) ? wptd_pkg::PHASE_FOOTER
                                                        : wptd_pkg::PHASE_BODY;
      end else begin
        res.code_point = xcode;
      end
    end else if (offset_r < text_end_r) begin
      res.section = wptd_pkg::PHASE_BODY;
      case (in_raw_byte)
        wptd_pkg::CODE_END: begin
          emit = 1'b1;
          res.item_kind = wptd_pkg::KIND_END;
          bold_nxt = 1'b0; ul_nxt = 1'b0; it_nxt = 1'b0;
          sub_nxt = 1'b0; sup_nxt = 1'b0; align_nxt = wptd_pkg::ALIGN_NORMAL;
        end
        wptd_pkg::CODE_FORMFEED, wptd_pkg::CODE_DROP: ;
        wptd_pkg::CODE_BOLD:      bold_nxt = !bold_r;
        wptd_pkg::CODE_UNDERLINE: ul_nxt = !ul_r;
        wptd_pkg::CODE_ITALIC:    it_nxt = !it_r;
        wptd_pkg::CODE_SUB: begin
          align_nxt = sub_r ? wptd_pkg::ALIGN_NORMAL : wptd_pkg::ALIGN_SUB;
          sub_nxt = !sub_r;
        end
        wptd_pkg::CODE_SUPER: begin
          align_nxt = sup_r ? wptd_pkg::ALIGN_NORMAL : wptd_pkg::ALIGN_SUPER;
          sup_nxt = !sup_r;
        end
        default: begin
          emit = 1'b1;
          res.code_point = xcode;
          res.bold = bold_r;
          res.underline = ul_r;
          res.italic = it_r;
          res.vertical_align = align_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_format_r <= 1'b0;
      text_end_r <= wptd_pkg::START_OFFSET;
      phase_r <= wptd_pkg::PHASE_HEADER;
      offset_r <= wptd_pkg::START_OFFSET;
      bold_r <= 1'b0; ul_r <= 1'b0; it_r <= 1'b0;
      sub_r <= 1'b0; sup_r <= 1'b0; align_r <= wptd_pkg::ALIGN_NORMAL;
    end else begin
      if (cfg_we) begin
        if (cfg_index == wptd_pkg::CFG_PC_FORMAT) pc_format_r <= cfg_data[0];
        else text_end_r <= cfg_data;
      end
      if (accept) begin
        phase_r <= phase_nxt;
        if (offset_r != 32'hFFFF_FFFF) offset_r <= offset_r + 32'd1;
        bold_r <= bold_nxt; ul_r <= ul_nxt; it_r <= it_nxt;
        sub_r <= sub_nxt; sup_r <= sup_nxt; align_r <= align_nxt;
      end
    end
  end

  // output register with skid entry
  logic push;
  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (!out_v_r || out_take) begin
        if (skid_v_r) begin
          out_v_r <= 1'b1;
          skid_v_r <= push;
        end else begin
          out_v_r <= push;
        end
      end else if (push) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_take) begin
      if (skid_v_r) begin
        out_r <= skid_r;
        if (push) skid_r <= res;
      end else if (push) begin
        out_r <= res;
      end
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_valid          = out_v_r;
  assign out_item_kind      = out_r.item_kind;
  assign out_section        = out_r.section;
  assign out_code_point     = out_r.code_point;
  assign out_bold           = out_r.bold;
  assign out_underline      = out_r.underline;
  assign out_italic         = out_r.italic;
  assign out_vertical_align = out_r.vertical_align;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r) else $error("skid entry without output word");
  a_no_body_in_header: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.section != wptd_pkg::PHASE_BODY) |->
      (!out_r.bold && !out_r.underline && !out_r.italic))
    else $error("attributes on header or footer word");
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.item_kind == wptd_pkg::KIND_END) |-> out_r.code_point == 16'd0)
    else $error("end word with code point");
`endif

endmodule
